### hdl/srwd_pkg.sv
// Shared types and constants of the serial register-write deframer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package srwd_pkg;

  // Marker bytes of the reset and initiator sequences
  localparam logic [7:0] MARK_A = 8'hFF;
  localparam logic [7:0] MARK_B = 8'hEE;
  localparam logic [7:0] MARK_C = 8'hDD;

  // Frame lengths and the fixed write delay of the short frame
  localparam logic [3:0] MODE_TWO   = 4'd2;
  localparam logic [3:0] MODE_FOUR  = 4'd4;
  localparam logic [3:0] MODE_EIGHT = 4'd8;
  localparam logic [15:0] SHORT_DELAY = 16'd6;

  localparam int unsigned FRAME_DEPTH = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_WRITE = 2'd1,
    EV_SIZE  = 2'd2,
    EV_RESET = 2'd3
  } event_kind_e;

  // A received byte with its marker classification
  typedef struct packed {
    logic [7:0] data;
    logic       is_a;
    logic       is_b;
    logic       is_c;
  } byte_class_t;

  // One result item
  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  reg_address;
    logic [7:0]  reg_value;
    logic [15:0] cycle_count;
    logic [3:0]  frame_size;
    logic        session_active;
  } event_t;

endpackage

`default_nettype wire

### hdl/srwd_if.sv
// Handshake channels of the deframer: received bytes in, events out.
// Depends on srwd_pkg for the event kind type.
`default_nettype none

interface srwd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface srwd_event_if;
  logic                      valid;
  logic                      ready;
  srwd_pkg::event_kind_e     event_kind;
  logic [7:0]                reg_address;
  logic [7:0]                reg_value;
  logic [15:0]               cycle_count;
  logic [3:0]                frame_size;
  logic                      session_active;

  modport source (output valid, output event_kind, output reg_address, output reg_value,
                  output cycle_count, output frame_size, output session_active,
                  input ready);
  modport sink (input valid, input event_kind, input reg_address, input reg_value,
                input cycle_count, input frame_size, input session_active,
                output ready);
endinterface

`default_nettype wire

### hdl/srwd_front.sv
// Front end: accepts received bytes and tags them with their marker class.
// Depends on srwd_pkg and srwd_if; feeds srwd_queue.
`default_nettype none

module srwd_front (
  srwd_byte_if.sink            byte_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output srwd_pkg::byte_class_t entry_o
);

  // Accept whenever the queue has room
  assign byte_i.ready = ~full_i;
  assign push_o       = byte_i.valid & ~full_i;

  // Classify the byte against the marker values
  always_comb begin
    entry_o.data = byte_i.rx_byte;
    entry_o.is_a = (byte_i.rx_byte == srwd_pkg::MARK_A);
    entry_o.is_b = (byte_i.rx_byte == srwd_pkg::MARK_B);
    entry_o.is_c = (byte_i.rx_byte == srwd_pkg::MARK_C);
  end

endmodule

`default_nettype wire

### hdl/srwd_queue.sv
// Short queue of classified bytes between front and back end.
// Depends on srwd_pkg.
`default_nettype none

module srwd_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire srwd_pkg::byte_class_t data_i,
  input  wire logic                  pop_i,
  output srwd_pkg::byte_class_t      data_o,
  output logic                       full_o,
  output logic                       empty_o
);

  localparam int unsigned Depth = srwd_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  srwd_pkg::byte_class_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/srwd_back.sv
// Back end: frame buffer, frame decoding and the registered event output.
// Depends on srwd_pkg and srwd_if; takes entries from srwd_queue.
`default_nettype none

module srwd_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire srwd_pkg::byte_class_t entry_i,
  input  wire logic                  empty_i,
  output logic                       pop_o,
  srwd_event_if.source               event_o
);

  localparam int unsigned Depth = srwd_pkg::FRAME_DEPTH;
  localparam int unsigned IdxW  = $clog2(Depth);

  srwd_pkg::byte_class_t store_q [Depth];
  srwd_pkg::byte_class_t store_d [Depth];
  srwd_pkg::byte_class_t cur     [Depth];
  logic [IdxW-1:0] idx_q, idx_d, idx;
  logic [3:0]      mode_q, mode_d;
  logic            active_q, active_d;
  srwd_pkg::event_t ev_q, ev_d;
  logic            ev_valid_q, ev_valid_d;
  logic            reset_hit, at_last, initiator, size_ok;
  logic [3:0]      mode_last;

  // Take an entry when the output register is free or being drained
  assign pop_o = ~empty_i & (~ev_valid_q | event_o.ready);

  // Decode the frame with the new byte in place
  always_comb begin
    idx = active_q ? idx_q : '0;
    for (int i = 0; i < Depth; i++) begin
      cur[i] = (IdxW'(i) == idx) ? entry_i : store_q[i];
    end
    reset_hit = (cur[0].is_a & cur[1].is_a) | (cur[1].is_a & cur[2].is_a)
              | (cur[2].is_a & cur[3].is_a);
    mode_last = mode_q - 4'd1;
    at_last   = (idx == mode_last[IdxW-1:0]);
    initiator = cur[0].is_a & cur[1].is_b & cur[2].is_c & cur[Depth-3].is_c
              & cur[Depth-2].is_b & cur[Depth-1].is_a;
    size_ok   = (cur[3].data == 8'd0)
              & ((cur[4].data == 8'(srwd_pkg::MODE_TWO))
               | (cur[4].data == 8'(srwd_pkg::MODE_FOUR)));
  end

  // Next frame state and result
  always_comb begin
    store_d    = store_q;
    idx_d      = idx_q;
    mode_d     = mode_q;
    active_d   = active_q;
    ev_d       = ev_q;
    ev_valid_d = ev_valid_q;
    if (event_o.ready) begin
      ev_valid_d = 1'b0;
    end
    if (pop_o) begin
      ev_valid_d        = 1'b1;
      ev_d.kind         = srwd_pkg::EV_NONE;
      ev_d.reg_address  = '0;
      ev_d.reg_value    = '0;
      ev_d.cycle_count  = '0;
      store_d           = cur;
      active_d          = 1'b1;
      if (reset_hit) begin
        for (int i = 0; i < Depth; i++) store_d[i] = '0;
        idx_d     = '0;
        mode_d    = srwd_pkg::MODE_EIGHT;
        active_d  = 1'b0;
        ev_d.kind = srwd_pkg::EV_RESET;
      end else if (at_last && (mode_q == srwd_pkg::MODE_TWO
                               || mode_q == srwd_pkg::MODE_FOUR)) begin
        ev_d.kind        = srwd_pkg::EV_WRITE;
        ev_d.reg_address = cur[0].data;
        ev_d.reg_value   = cur[1].data;
        ev_d.cycle_count = (mode_q == srwd_pkg::MODE_TWO) ? srwd_pkg::SHORT_DELAY
                                                          : {cur[2].data, cur[3].data};
        for (int i = 0; i < Depth; i++) store_d[i] = '0;
        idx_d = '0;
      end else if (at_last && mode_q == srwd_pkg::MODE_EIGHT) begin
        // Drop any eight-byte frame that is not a valid initiator with a supported size
        if (initiator && size_ok) begin
          mode_d    = cur[4].data[3:0];
          ev_d.kind = srwd_pkg::EV_SIZE;
        end
        for (int i = 0; i < Depth; i++) store_d[i] = '0;
        idx_d = '0;
      end else begin
        idx_d = idx + 1'b1;
      end
      ev_d.frame_size     = mode_d;
      ev_d.session_active = active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) store_q[i] <= '0;
      idx_q      <= '0;
      mode_q     <= srwd_pkg::MODE_EIGHT;
      active_q   <= 1'b0;
      ev_valid_q <= 1'b0;
    end else begin
      store_q    <= store_d;
      idx_q      <= idx_d;
      mode_q     <= mode_d;
      active_q   <= active_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  assign event_o.valid          = ev_valid_q;
  assign event_o.event_kind     = ev_q.kind;
  assign event_o.reg_address    = ev_q.reg_address;
  assign event_o.reg_value      = ev_q.reg_value;
  assign event_o.cycle_count    = ev_q.cycle_count;
  assign event_o.frame_size     = ev_q.frame_size;
  assign event_o.session_active = ev_q.session_active;

endmodule

`default_nettype wire

### hdl/serial_register_write_deframer_top.sv
// Top level of the serial register-write deframer.
// Depends on srwd_pkg, srwd_if, srwd_front, srwd_queue and srwd_back.
//
// Every received byte yields exactly one event item: none, register write,
// frame size set or reset, together with the frame size and session flag in
// force afterwards. One byte is taken per clock cycle while the queue has
// room; its event passes through the queue and then the output register of
// the back end. A two-entry queue between classification and decoding absorbs
// a stalled output, so input ready drops only after two bytes are held back.
`default_nettype none

module serial_register_write_deframer_top (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  srwd_byte_if.sink    byte_i,
  srwd_event_if.source event_o
);

  logic                  push, pop, full, empty;
  srwd_pkg::byte_class_t push_entry, pop_entry;

  srwd_front u_front (
    .byte_i  (byte_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  srwd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  srwd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (pop_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .event_o (event_o)
  );

  // Never write into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("queue push while full");

  // Frame size is always one of the supported lengths
  a_frame_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o.valid |-> (event_o.frame_size == srwd_pkg::MODE_TWO
                       || event_o.frame_size == srwd_pkg::MODE_FOUR
                       || event_o.frame_size == srwd_pkg::MODE_EIGHT))
    else $error("unsupported frame size reported");

  // Reset event ends the session and restores eight-byte frames
  a_reset_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && event_o.event_kind == srwd_pkg::EV_RESET)
    |-> (!event_o.session_active && event_o.frame_size == srwd_pkg::MODE_EIGHT))
    else $error("reset event with stale session state");

  // Write fields are zero unless the event is a write
  a_write_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && event_o.event_kind != srwd_pkg::EV_WRITE)
    |-> (event_o.reg_address == 8'd0 && event_o.reg_value == 8'd0
         && event_o.cycle_count == 16'd0))
    else $error("write fields set on a non-write event");

endmodule

`default_nettype wire
